FILE: rtl/apos_pkg.sv
// Package for the aspect-preserving output size block.
// Holds register indexes, port widths and reset values; no dependencies.
`default_nettype none
package apos_pkg;
    // Fixed port widths
    localparam int ASPECT_W   = 16;
    localparam int OUT_W      = 16;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;
    // Clamped quotient width: all ones stands for any larger value
    localparam int QUOT_W     = 17;

    // Parameter defaults
    localparam int DIM_BITS_DEF  = 13;
    localparam int FRAC_BITS_DEF = 12;

    // Register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_PIXEL_ASPECT  = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_SCREEN_WIDTH  = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_SCREEN_HEIGHT = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_ORIG_WIDTH    = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_ORIG_HEIGHT   = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_PRE_WIDTH     = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_PRE_HEIGHT    = 3'd6;

    // Reset values
    localparam int RST_ASPECT = 4096;
    localparam int RST_WIDTH  = 640;
    localparam int RST_HEIGHT = 480;
endpackage
`default_nettype wire

FILE: rtl/aspect_preserving_output_size.sv
// Top level: aspect-preserving output size, fully pipelined.
// Depends on apos_pkg and apos_div.
//
// One request per cycle is accepted (o_busy stays low); each result appears
// on o_valid for one cycle, after two multiply stages, the divider prep
// stage, the bit-per-stage divider stages and the registered final select
// stage. The receiver cannot stall. Configuration writes take effect
// at once and must be made while no request is in flight.
`default_nettype none
module aspect_preserving_output_size
    import apos_pkg::*;
#(
    parameter int DIM_BITS         = DIM_BITS_DEF,
    parameter int ASPECT_FRAC_BITS = FRAC_BITS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_start,
    output logic                       o_busy,
    input  wire logic                  i_zoom_on,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_wdata,
    output logic                       o_valid,
    output logic [OUT_W-1:0]           o_out_width,
    output logic [OUT_W-1:0]           o_out_height,
    output logic                       o_width_fitted
);
    localparam int D     = DIM_BITS;
    localparam int F     = ASPECT_FRAC_BITS;
    localparam int P     = ASPECT_W;
    localparam int NA_W  = 2 * D + P;
    localparam int DA_W  = D + F;
    localparam int NB_W  = 2 * D + F;
    localparam int DB_W  = D + P;
    localparam int HNZ_W = D + P - F;
    localparam int H_W   = QUOT_W + 1;

    // Configuration registers
    logic [P-1:0] r_aspect;
    logic [D-1:0] r_sw, r_sh, r_ow, r_oh, r_pw, r_ph;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_aspect <= P'(RST_ASPECT);
            r_sw     <= D'(RST_WIDTH);
            r_sh     <= D'(RST_HEIGHT);
            r_ow     <= D'(RST_WIDTH);
            r_oh     <= D'(RST_HEIGHT);
            r_pw     <= D'(RST_WIDTH);
            r_ph     <= D'(RST_HEIGHT);
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                REG_PIXEL_ASPECT:  r_aspect <= i_cfg_wdata[P-1:0];
                REG_SCREEN_WIDTH:  r_sw     <= i_cfg_wdata[D-1:0];
                REG_SCREEN_HEIGHT: r_sh     <= i_cfg_wdata[D-1:0];
                REG_ORIG_WIDTH:    r_ow     <= i_cfg_wdata[D-1:0];
                REG_ORIG_HEIGHT:   r_oh     <= i_cfg_wdata[D-1:0];
                REG_PRE_WIDTH:     r_pw     <= i_cfg_wdata[D-1:0];
                REG_PRE_HEIGHT:    r_ph     <= i_cfg_wdata[D-1:0];
                default: ;
            endcase
        end
    end

    assign o_busy = 1'b0;

    // Stage 1: first products
    logic              r_s1_vld, r_s1_zoom, r_s1_land;
    logic [2*D-1:0]    r_s1_swph, r_s1_shpw;
    logic [D+P-1:0]    r_s1_php;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else begin
            r_s1_vld <= i_start && !o_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_zoom <= i_zoom_on;
        r_s1_land <= r_pw >= r_ph;
        r_s1_swph <= r_sw * r_ph;
        r_s1_shpw <= r_sh * r_pw;
        r_s1_php  <= r_ph * r_aspect;
    end

    // Stage 2: divider operands and the unzoomed height
    logic              r_s2_vld, r_s2_zoom, r_s2_land;
    logic [NA_W-1:0]   r_s2_num_a;
    logic [DA_W-1:0]   r_s2_den_a;
    logic [NB_W-1:0]   r_s2_num_b;
    logic [DB_W-1:0]   r_s2_den_b;
    logic [QUOT_W-1:0] r_s2_hnz;
    logic [HNZ_W-1:0]  hnz_full;

    assign hnz_full = HNZ_W'(r_s1_php >> F);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else begin
            r_s2_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2_zoom  <= r_s1_zoom;
        r_s2_land  <= r_s1_land;
        r_s2_num_a <= r_s1_swph * r_aspect;
        r_s2_den_a <= DA_W'(r_pw) << F;
        r_s2_num_b <= r_s1_zoom ? (NB_W'(r_s1_shpw) << F) : (NB_W'(r_pw) << F);
        r_s2_den_b <= r_s1_zoom ? r_s1_php : DB_W'(r_aspect);
        r_s2_hnz   <= (hnz_full > HNZ_W'({QUOT_W{1'b1}})) ? '1 : QUOT_W'(hnz_full);
    end

    // Dividers: landscape height and width candidate
    logic              div_a_vld, div_b_vld;
    logic [QUOT_W-1:0] q_a, q_b;

    apos_div #(.NUM_W(NA_W), .DEN_W(DA_W), .Q_W(QUOT_W)) u_div_h (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(r_s2_vld),
        .i_num  (r_s2_num_a),
        .i_den  (r_s2_den_a),
        .o_valid(div_a_vld),
        .o_quot (q_a)
    );

    apos_div #(.NUM_W(NB_W), .DEN_W(DB_W), .Q_W(QUOT_W)) u_div_w (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(r_s2_vld),
        .i_num  (r_s2_num_b),
        .i_den  (r_s2_den_b),
        .o_valid(div_b_vld),
        .o_quot (q_b)
    );

    // Side pipe matching divider latency
    logic              r_sd_zoom [0:QUOT_W];
    logic              r_sd_land [0:QUOT_W];
    logic [QUOT_W-1:0] r_sd_hnz  [0:QUOT_W];

    always_ff @(posedge i_clk) begin
        r_sd_zoom[0] <= r_s2_zoom;
        r_sd_land[0] <= r_s2_land;
        r_sd_hnz[0]  <= r_s2_hnz;
        for (int i = 1; i <= QUOT_W; i++) begin
            r_sd_zoom[i] <= r_sd_zoom[i-1];
            r_sd_land[i] <= r_sd_land[i-1];
            r_sd_hnz[i]  <= r_sd_hnz[i-1];
        end
    end

    // Final select: round height, try the width-fitted candidate, saturate
    logic           zm, land, fit;
    logic [H_W-1:0] h_raw, h_even, w_base, cand, n_w, n_h;

    assign zm     = r_sd_zoom[QUOT_W];
    assign land   = r_sd_land[QUOT_W];
    assign cand   = H_W'(q_b);
    assign h_raw  = zm ? (land ? H_W'(q_a) : H_W'(r_sh)) : H_W'(r_sd_hnz[QUOT_W]);
    assign h_even = h_raw + H_W'(h_raw[0]);
    assign w_base = zm ? (land ? H_W'(r_sw) : cand) : H_W'(r_pw);
    assign fit    = ((h_even > H_W'(r_sh)) || (h_even < H_W'(r_oh)))
                    && (cand <= H_W'(r_sw)) && (cand >= H_W'(r_ow));
    assign n_w    = fit ? (cand + H_W'(cand[0])) : w_base;
    assign n_h    = fit ? (zm ? H_W'(r_sh) : H_W'(r_ph)) : h_even;

    logic r_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= div_a_vld && div_b_vld;
        end
    end

    logic [OUT_W-1:0] r_w, r_h;
    logic             r_fit;

    always_ff @(posedge i_clk) begin
        r_w   <= (n_w > H_W'({OUT_W{1'b1}})) ? '1 : OUT_W'(n_w);
        r_h   <= (n_h > H_W'({OUT_W{1'b1}})) ? '1 : OUT_W'(n_h);
        r_fit <= fit;
    end

    assign o_valid        = r_vld;
    assign o_out_width    = r_w;
    assign o_out_height   = r_h;
    assign o_width_fitted = r_fit;
endmodule
`default_nettype wire

FILE: rtl/apos_div.sv
// Pipelined restoring divider, one quotient bit per stage, clamped quotient.
// Uses no package; instantiated by the top level.
`default_nettype none
module apos_div #(
    parameter int NUM_W = 42,
    parameter int DEN_W = 29,
    parameter int Q_W   = 17
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    input  wire logic [NUM_W-1:0] i_num,
    input  wire logic [DEN_W-1:0] i_den,
    output logic                  o_valid,
    output logic [Q_W-1:0]        o_quot
);
    localparam int W = NUM_W + DEN_W + Q_W;

    logic [W-1:0]   r_rem [0:Q_W-1];
    logic [W-1:0]   r_den [0:Q_W-1];
    logic [Q_W-1:0] r_q   [0:Q_W];
    logic           r_ovf [0:Q_W];
    logic           r_vld [0:Q_W];

    // Prep stage: flag zero divisor and quotients that do not fit Q_W bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else begin
            r_vld[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem[0] <= W'(i_num);
        r_den[0] <= W'(i_den);
        r_q[0]   <= '0;
        r_ovf[0] <= (i_den == '0) || (W'(i_num) >= (W'(i_den) << Q_W));
    end

    // Bit stages, most significant quotient bit first
    for (genvar s = 1; s <= Q_W; s++) begin : g_stage
        localparam int K = Q_W - s;
        logic [W-1:0] trial;
        logic         ge;
        assign trial = r_den[s-1] << K;
        assign ge    = r_rem[s-1] >= trial;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else begin
                r_vld[s] <= r_vld[s-1];
            end
        end

        always_ff @(posedge i_clk) begin
            r_q[s]   <= {r_q[s-1][Q_W-2:0], ge};
            r_ovf[s] <= r_ovf[s-1];
        end

        if (s < Q_W) begin : g_rem
            always_ff @(posedge i_clk) begin
                r_rem[s] <= ge ? (r_rem[s-1] - trial) : r_rem[s-1];
                r_den[s] <= r_den[s-1];
            end
        end
    end

    assign o_valid = r_vld[Q_W];
    assign o_quot  = r_ovf[Q_W] ? '1 : r_q[Q_W];
endmodule
`default_nettype wire

FILE: dv/tb_top.sv
// Testbench for aspect_preserving_output_size: directed and random requests
// checked against an in-bench fixed-point predictor. Depends on apos_pkg and the RTL.
`timescale 1ns / 1ps
module tb_top;
    import apos_pkg::*;

    localparam logic [CFG_ADDR_W-1:0] REG_UNUSED = 3'd7;
    localparam int LATENCY = 21;
    localparam int CYCLE_LIMIT = 400000;
    localparam longint unsigned SAT = 65535;
    localparam int FRAC = FRAC_BITS_DEF;
    localparam longint unsigned DIM_MASK = (1 << DIM_BITS_DEF) - 1;

    typedef struct {
        logic [OUT_W-1:0] width;
        logic [OUT_W-1:0] height;
        logic             fitted;
    } t_size;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_start = 1'b0;
    logic                  i_zoom_on = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0] i_cfg_addr = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;
    logic                  o_busy;
    logic                  o_valid;
    logic [OUT_W-1:0]      o_out_width;
    logic [OUT_W-1:0]      o_out_height;
    logic                  o_width_fitted;

    // Shadow copy of the configuration registers
    longint unsigned sh_aspect, sh_scr_w, sh_scr_h, sh_org_w, sh_org_h, sh_pre_w, sh_pre_h;

    t_size pending_sizes[$];
    int    errors = 0;
    int    cycles = 0;
    bit    allow_idle = 1'b1;

    aspect_preserving_output_size i_dut (
        .i_clk, .i_rst_n, .i_start, .o_busy, .i_zoom_on,
        .i_cfg_we, .i_cfg_addr, .i_cfg_wdata,
        .o_valid, .o_out_width, .o_out_height, .o_width_fitted
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Cycle counter and timeout
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    function automatic longint unsigned safe_div(longint unsigned num, longint unsigned den);
        return (den == 0) ? SAT : num / den;
    endfunction

    function automatic logic [OUT_W-1:0] clamp16(longint unsigned v);
        return (v > SAT) ? OUT_W'(SAT) : OUT_W'(v);
    endfunction

    // Expected output size for one request under the current configuration
    function automatic t_size fit_size(logic zoom);
        longint unsigned w, h, cand;
        t_size r;
        r.fitted = 1'b0;
        if (zoom) begin
            if (sh_pre_w >= sh_pre_h) begin
                w = sh_scr_w;
                h = safe_div(sh_scr_w * sh_pre_h * sh_aspect, sh_pre_w << FRAC);
            end else begin
                h = sh_scr_h;
                w = safe_div((sh_scr_h * sh_pre_w) << FRAC, sh_pre_h * sh_aspect);
            end
        end else begin
            w = sh_pre_w;
            h = (sh_pre_h * sh_aspect) >> FRAC;
        end
        h = h + (h & 1);
        // Height out of range: try the width-fitted candidate
        if (h > sh_scr_h || h < sh_org_h) begin
            if (zoom)
                cand = safe_div((sh_scr_h * sh_pre_w) << FRAC, sh_pre_h * sh_aspect);
            else
                cand = safe_div(sh_pre_w << FRAC, sh_aspect);
            if (cand <= sh_scr_w && cand >= sh_org_w) begin
                h = zoom ? sh_scr_h : sh_pre_h;
                w = cand + (cand & 1);
                r.fitted = 1'b1;
            end
        end
        r.width = clamp16(w);
        r.height = clamp16(h);
        return r;
    endfunction

    // Result checker: one word per strobe against the oldest expectation
    always @(posedge i_clk) begin
        t_size exp_sz;
        if (i_rst_n && o_valid) begin
            if (pending_sizes.size() == 0) begin
                $display("%0t: unexpected result w=%0d h=%0d f=%0b", $time,
                         o_out_width, o_out_height, o_width_fitted);
                errors++;
            end else begin
                exp_sz = pending_sizes.pop_front();
                if (o_out_width !== exp_sz.width) begin
                    $display("%0t: width exp %0d got %0d", $time, exp_sz.width, o_out_width);
                    errors++;
                end
                if (o_out_height !== exp_sz.height) begin
                    $display("%0t: height exp %0d got %0d", $time, exp_sz.height,
                             o_out_height);
                    errors++;
                end
                if (o_width_fitted !== exp_sz.fitted) begin
                    $display("%0t: fitted exp %0b got %0b", $time, exp_sz.fitted,
                             o_width_fitted);
                    errors++;
                end
            end
        end
    end

    // Send one request word; start stays high for back-to-back words
    task automatic send_word(logic zoom);
        i_start <= 1'b1;
        i_zoom_on <= zoom;
        do @(posedge i_clk); while (o_busy);
        pending_sizes.push_back(fit_size(zoom));
    endtask

    task automatic maybe_idle();
        if (allow_idle && $urandom_range(0, 7) == 0) begin
            i_start <= 1'b0;
            i_zoom_on <= 1'($urandom_range(0, 1));
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
    endtask

    task automatic wait_idle();
        i_start <= 1'b0;
        @(posedge i_clk);
        while (pending_sizes.size() != 0) @(posedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_PIXEL_ASPECT:  sh_aspect = val;
            REG_SCREEN_WIDTH:  sh_scr_w = val & DIM_MASK;
            REG_SCREEN_HEIGHT: sh_scr_h = val & DIM_MASK;
            REG_ORIG_WIDTH:    sh_org_w = val & DIM_MASK;
            REG_ORIG_HEIGHT:   sh_org_h = val & DIM_MASK;
            REG_PRE_WIDTH:     sh_pre_w = val & DIM_MASK;
            REG_PRE_HEIGHT:    sh_pre_h = val & DIM_MASK;
            default: ;
        endcase
    endtask

    task automatic set_all(logic [CFG_DATA_W-1:0] asp, logic [CFG_DATA_W-1:0] sw,
                           logic [CFG_DATA_W-1:0] sh, logic [CFG_DATA_W-1:0] ow,
                           logic [CFG_DATA_W-1:0] oh, logic [CFG_DATA_W-1:0] pw,
                           logic [CFG_DATA_W-1:0] ph);
        write_reg(REG_PIXEL_ASPECT, asp);
        write_reg(REG_SCREEN_WIDTH, sw);
        write_reg(REG_SCREEN_HEIGHT, sh);
        write_reg(REG_ORIG_WIDTH, ow);
        write_reg(REG_ORIG_HEIGHT, oh);
        write_reg(REG_PRE_WIDTH, pw);
        write_reg(REG_PRE_HEIGHT, ph);
    endtask

    // Random dimension: mostly plausible sizes, sometimes edges; stray high bits
    function automatic logic [CFG_DATA_W-1:0] rand_dim();
        logic [CFG_DATA_W-1:0] v;
        case ($urandom_range(0, 9))
            0:       v = 0;
            1:       v = 1;
            2:       v = 8191;
            3:       v = CFG_DATA_W'($urandom_range(0, 8191));
            default: v = CFG_DATA_W'($urandom_range(100, 2000));
        endcase
        if ($urandom_range(0, 5) == 0) v[15:13] = 3'($urandom_range(0, 7));
        return v;
    endfunction

    function automatic logic [CFG_DATA_W-1:0] rand_aspect();
        case ($urandom_range(0, 9))
            0:       return 0;
            1:       return 65535;
            2:       return 4096;
            3:       return CFG_DATA_W'($urandom_range(0, 65535));
            default: return CFG_DATA_W'($urandom_range(2048, 8192));
        endcase
    endfunction

    task automatic test_defaults();
        send_word(1'b0);
        send_word(1'b1);
        wait_idle();
    endtask

    task automatic test_directed();
        // Tall pixels, height overflows the screen, width-fitted fallback taken
        set_all(8192, 640, 480, 300, 200, 640, 480);
        send_word(1'b0);
        send_word(1'b1);
        wait_idle();
        // Portrait source under zoom
        set_all(3000, 1024, 768, 100, 100, 480, 640);
        send_word(1'b1);
        send_word(1'b0);
        wait_idle();
        // Zero aspect: every width division is by zero
        write_reg(REG_PIXEL_ASPECT, 0);
        send_word(1'b1);
        send_word(1'b0);
        wait_idle();
        // Zero prescaled height and width
        set_all(4096, 640, 480, 0, 0, 0, 0);
        send_word(1'b1);
        send_word(1'b0);
        wait_idle();
        // All at maximum: the height saturates in both modes
        set_all(65535, 8191, 8191, 8191, 8191, 8191, 8191);
        send_word(1'b1);
        send_word(1'b0);
        wait_idle();
        write_reg(REG_PRE_HEIGHT, 1);
        send_word(1'b1);
        send_word(1'b0);
        wait_idle();
        // Wide values keep only the low bits; unused index is ignored
        write_reg(REG_SCREEN_WIDTH, 16'hFFFF);
        write_reg(REG_UNUSED, 16'hFFFF);
        write_reg(REG_PIXEL_ASPECT, 1);
        send_word(1'b1);
        send_word(1'b0);
        wait_idle();
        set_all(0, 0, 0, 0, 0, 0, 0);
        send_word(1'b1);
        send_word(1'b0);
        wait_idle();
    endtask

    task automatic test_random();
        int n_items;
        for (int ph = 0; ph < 40; ph++) begin
            allow_idle = (ph < 34);
            set_all(rand_aspect(), rand_dim(), rand_dim(), rand_dim(), rand_dim(),
                    rand_dim(), rand_dim());
            if ($urandom_range(0, 3) == 0) write_reg(REG_UNUSED, CFG_DATA_W'($urandom()));
            n_items = $urandom_range(25, 50);
            for (int k = 0; k < n_items; k++) begin
                send_word(1'($urandom_range(0, 1)));
                maybe_idle();
            end
            wait_idle();
        end
    endtask

    initial begin
        sh_aspect = RST_ASPECT;
        sh_scr_w = RST_WIDTH;
        sh_scr_h = RST_HEIGHT;
        sh_org_w = RST_WIDTH;
        sh_org_h = RST_HEIGHT;
        sh_pre_w = RST_WIDTH;
        sh_pre_h = RST_HEIGHT;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_defaults();
        test_directed();
        test_random();
        repeat (LATENCY + 10) @(posedge i_clk);
        if (errors == 0 && pending_sizes.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule

FILE: sim.f
rtl/apos_pkg.sv
rtl/apos_div.sv
rtl/aspect_preserving_output_size.sv
dv/tb_top.sv
